// ===== hw/rtl/pwlc_pkg.sv =====
// Package for the piecewise linear curve lookup.
// Holds parameter defaults, command codes and result status codes.
// Used by pwlc_ram and piecewise_linear_curve_lookup.
package pwlc_pkg;

    localparam int MAX_KNOTS_DEF  = 16;
    localparam int TIME_BITS_DEF  = 24;
    localparam int VALUE_BITS_DEF = 20;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STS_INTERP       = 2'd0,
        STS_EXACT        = 2'd1,
        STS_OUT_OF_RANGE = 2'd2
    } t_status;

endpackage

// ===== hw/rtl/piecewise_linear_curve_lookup.sv =====
// Piecewise linear curve lookup: a knot table in RAM, a serial scan and a
// radix-2 multiply-divide unit. Depends on pwlc_pkg and pwlc_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries load and query items.
//   A load item writes one knot (time, value) into the table and gives no
//   result. A query item gives one result item on the output channel
//   (o_out_valid / i_out_ready): the curve value and a status of
//   interpolated, exact knot or out of range.
//   The knot count register is written through i_cfg_wr_en / i_cfg_wr_data
//   and the user must write it only while the block is idle, as the block
//   itself does not enforce this; counts above MAX_KNOTS act as MAX_KNOTS.
//   A query reads one knot per cycle from the table RAM until the segment is
//   found. An interpolation then passes a set-up step and the multiply-divide
//   unit, one quotient digit a cycle. The block takes no new item while a
//   query is in progress and is ready again as its result appears.
// Reset and stalls
//   Reset clears the knot count and the output valid; the knot table is not
//   cleared and must be loaded before it is queried. If the receiver stalls,
//   the result waits in the output register and items are still taken until
//   the next query finishes; that query then waits for the register to drain
//   and no item is taken meanwhile.
module piecewise_linear_curve_lookup
    import pwlc_pkg::*;
#(
    parameter int MAX_KNOTS  = MAX_KNOTS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [$clog2(MAX_KNOTS+1)-1:0]   i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_command,
    input  logic [$clog2(MAX_KNOTS)-1:0]     i_knot_index,
    input  logic [TIME_BITS-1:0]             i_knot_time,
    input  logic [VALUE_BITS-1:0]            i_knot_value,
    input  logic [TIME_BITS-1:0]             i_query_time,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [VALUE_BITS-1:0]            o_curve_value,
    output logic [1:0]                       o_status
);

    localparam int KCW = $clog2(MAX_KNOTS + 1);
    localparam int KIW = $clog2(MAX_KNOTS);
    localparam int TB  = TIME_BITS;
    localparam int VB  = VALUE_BITS;
    localparam int SW  = TIME_BITS + 3;
    localparam int CW  = $clog2(VALUE_BITS + 1);
    localparam logic [KCW-1:0] MAX_CNT   = KCW'(MAX_KNOTS);
    localparam logic [KCW-1:0] TWO_CNT   = KCW'(2);
    localparam logic [CW-1:0]  STEP_LAST = CW'(1);
    localparam logic [CW-1:0]  STEP_INIT = CW'(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_FINISH
    } t_state;

    t_state          r_state;
    logic [KCW-1:0]  r_count;
    logic [KCW-1:0]  r_idx;
    logic [TB-1:0]   r_t;
    logic [TB-1:0]   r_x1;
    logic [VB-1:0]   r_y1;
    logic [TB-1:0]   r_dt;
    logic [TB-1:0]   r_span;
    logic [VB-1:0]   r_dy;
    logic            r_neg;
    logic [SW-1:0]   r_dt_m1;
    logic [SW-1:0]   r_dt_m2;
    logic [SW-1:0]   r_m1;
    logic [SW-1:0]   r_m2;
    logic [SW-1:0]   r_rem;
    logic [VB-1:0]   r_q;
    logic [CW-1:0]   r_step;
    t_status         r_res_status;
    logic            r_out_valid;
    logic [VB-1:0]   r_curve_value;
    t_status         r_status;

    logic            w_in_acc;
    logic            w_load_we;
    logic            w_rd_en;
    logic [KIW-1:0]  w_rd_addr;
    logic [TB+VB-1:0] w_rd_data;
    logic [TB-1:0]   w_x2;
    logic [VB-1:0]   w_y2;
    logic [KCW-1:0]  w_n_eff;
    logic [KCW-1:0]  n_idx;
    logic            w_exact;
    logic            w_inside;
    logic            w_cont;
    logic [SW-1:0]   w_twice;
    logic [SW-1:0]   w_a0;
    logic [SW-1:0]   w_a1;
    logic [SW-1:0]   w_a2;
    logic [SW-1:0]   w_c0;
    logic [SW-1:0]   w_c1;
    logic [SW-1:0]   w_c2;
    logic [SW-1:0]   n_rem;
    logic [1:0]      w_digit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load_we  = w_in_acc && (i_command == CMD_LOAD)
                        && (KCW'(i_knot_index) < MAX_CNT);

    assign w_n_eff = (r_count > MAX_CNT) ? MAX_CNT : r_count;
    assign w_x2    = w_rd_data[TB+VB-1:VB];
    assign w_y2    = w_rd_data[VB-1:0];
    assign n_idx   = r_idx + KCW'(1);

    // Segment test for the knot that the RAM returns this cycle. On the
    // first knot only the exact match applies, as there is no segment yet.
    assign w_exact  = (r_t == w_x2);
    assign w_inside = (r_idx != '0) && (r_t > r_x1) && (r_t < w_x2);
    assign w_cont   = !w_exact && !w_inside && (n_idx < w_n_eff);

    assign w_rd_en   = (w_in_acc && (i_command == CMD_QUERY))
                       || ((r_state == S_SCAN) && w_cont);
    assign w_rd_addr = (r_state == S_SCAN) ? n_idx[KIW-1:0] : '0;

    pwlc_ram #(
        .WIDTH (TB + VB),
        .DEPTH (MAX_KNOTS)
    ) u_knot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load_we),
        .i_wr_addr (i_knot_index),
        .i_wr_data ({i_knot_time, i_knot_value}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // One step of the fused multiply-divide. It keeps
    // q * span + rem = (leading bits of dy) * dt with rem below span, so each
    // step brings in one bit of dy and yields a quotient digit of 0, 1 or 2.
    assign w_twice = {r_rem[SW-2:0], 1'b0};
    assign w_a0    = r_dy[VB-1] ? {3'b000, r_dt} : '0;
    assign w_a1    = r_dy[VB-1] ? r_dt_m1 : r_m1;
    assign w_a2    = r_dy[VB-1] ? r_dt_m2 : r_m2;
    assign w_c0    = w_twice + w_a0;
    assign w_c1    = w_twice + w_a1;
    assign w_c2    = w_twice + w_a2;

    always_comb begin
        if (!w_c2[SW-1]) begin
            n_rem   = w_c2;
            w_digit = 2'd2;
        end else if (!w_c1[SW-1]) begin
            n_rem   = w_c1;
            w_digit = 2'd1;
        end else begin
            n_rem   = w_c0;
            w_digit = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_command == CMD_QUERY)) begin
                        r_t   <= i_query_time;
                        r_idx <= '0;
                        if (w_n_eff < TWO_CNT) begin
                            r_y1         <= '0;
                            r_q          <= '0;
                            r_neg        <= 1'b0;
                            r_res_status <= STS_OUT_OF_RANGE;
                            r_state      <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_exact) begin
                        r_y1         <= w_y2;
                        r_q          <= '0;
                        r_neg        <= 1'b0;
                        r_res_status <= STS_EXACT;
                        r_state      <= S_FINISH;
                    end else if (w_inside) begin
                        r_dt         <= r_t - r_x1;
                        r_span       <= w_x2 - r_x1;
                        r_neg        <= (w_y2 < r_y1);
                        r_dy         <= (w_y2 < r_y1) ? (r_y1 - w_y2) : (w_y2 - r_y1);
                        r_res_status <= STS_INTERP;
                        r_state      <= S_PREP;
                    end else if (w_cont) begin
                        r_x1  <= w_x2;
                        r_y1  <= w_y2;
                        r_idx <= n_idx;
                    end else begin
                        r_y1         <= '0;
                        r_q          <= '0;
                        r_neg        <= 1'b0;
                        r_res_status <= STS_OUT_OF_RANGE;
                        r_state      <= S_FINISH;
                    end
                end
                S_PREP: begin
                    r_dt_m1 <= {3'b000, r_dt} - {3'b000, r_span};
                    r_dt_m2 <= {3'b000, r_dt} - {2'b00, r_span, 1'b0};
                    r_m1    <= '0 - {3'b000, r_span};
                    r_m2    <= '0 - {2'b00, r_span, 1'b0};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_step  <= STEP_INIT;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_q    <= {r_q[VB-2:0], 1'b0} + VB'(w_digit);
                    r_dy   <= {r_dy[VB-2:0], 1'b0};
                    r_step <= r_step - CW'(1);
                    if (r_step == STEP_LAST) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_curve_value <= r_neg ? (r_y1 - r_q) : (r_y1 + r_q);
                        r_status      <= r_res_status;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_curve_value = r_curve_value;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (!r_rem[SW-1] && (r_rem[SW-2:0] < {2'b00, r_span})))
        else $error("divider remainder not below the segment span");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < w_n_eff))
        else $error("scan index beyond the knots in use");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> (r_span != '0))
        else $error("interpolation started on an empty segment");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_command == CMD_QUERY)) |=> !o_in_ready)
        else $error("input ready straight after a query item");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STS_OUT_OF_RANGE)) |-> (o_curve_value == '0))
        else $error("out of range result with a non-zero value");
`endif

endmodule

// ===== hw/rtl/pwlc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on pwlc_pkg for default sizes only.
module pwlc_ram
    import pwlc_pkg::*;
#(
    parameter int WIDTH = TIME_BITS_DEF + VALUE_BITS_DEF,
    parameter int DEPTH = MAX_KNOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
